// ===== rtl/chip8eu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package chip8eu_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STACK_AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW = $clog2(MEM_BYTES);

  localparam logic [11:0] PC_RESET = 12'd512;
  localparam logic [1:0] ADDR_START_PC = 2'd0;

  localparam logic [1:0] CMD_EXEC = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_VREG = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_UNIMPL = 2'd3;

  localparam logic [3:0] OP_SYS = 4'h0;
  localparam logic [3:0] OP_JP = 4'h1;
  localparam logic [3:0] OP_CALL = 4'h2;
  localparam logic [3:0] OP_SEI = 4'h3;
  localparam logic [3:0] OP_SNEI = 4'h4;
  localparam logic [3:0] OP_SER = 4'h5;
  localparam logic [3:0] OP_LDI = 4'h6;
  localparam logic [3:0] OP_ADDI = 4'h7;
  localparam logic [3:0] OP_ALU = 4'h8;
  localparam logic [3:0] OP_SNER = 4'h9;
  localparam logic [3:0] OP_LDIDX = 4'hA;
  localparam logic [3:0] OP_JPV0 = 4'hB;
  localparam logic [3:0] OP_RND = 4'hC;
  localparam logic [3:0] OP_MISC = 4'hF;

  localparam logic [15:0] OPC_RET = 16'h00EE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] FX_ADDIDX = 8'h1E;
  localparam logic [7:0] FX_BCD = 8'h33;
  localparam logic [7:0] FX_STORE = 8'h55;
  localparam logic [7:0] FX_LOAD = 8'h65;

  localparam logic [3:0] VF = 4'hF;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_WB   = 6'b000100,
    S_LOOP = 6'b001000,
    S_BCD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [16:0] a);
    mem_addr = a[MEM_AW-1:0];
  endfunction

  // hundreds, tens, ones
  function automatic logic [11:0] bcd_digits(input logic [7:0] v);
    logic [3:0] h;
    logic [7:0] r;
    logic [14:0] p;
    logic [3:0] t;
    logic [7:0] o;
    if (v >= 8'd200) begin
      h = 4'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 4'd1;
      r = v - 8'd100;
    end else begin
      h = 4'd0;
      r = v;
    end
    p = {8'b0, r[6:0]} * 15'd205;
    t = p[14:11];
    o = r - ({4'b0, t} * 8'd10);
    bcd_digits = {h, t, o[3:0]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/chip8eu_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module chip8eu_ram #(
  parameter int W = 8,
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/chip8eu_vregs.sv =====
`timescale 1ns / 1ps
`default_nettype none
module chip8eu_vregs (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [3:0] raddr_a,
  input  wire logic [3:0] raddr_b,
  output logic      [7:0] rdata_a,
  output logic      [7:0] rdata_b,
  input  wire logic       we,
  input  wire logic [3:0] waddr,
  input  wire logic [7:0] wdata
);

  logic [7:0] regs [16];
  logic [15:0] written;

  always_ff @(posedge clk) begin
    if (we) begin
      regs[waddr] <= wdata;
    end
  end

  // unwritten entries read as zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= written[raddr_a] ? regs[raddr_a] : 8'd0;
    rdata_b <= written[raddr_b] ? regs[raddr_b] : 8'd0;
  end

endmodule
`default_nettype wire

// ===== rtl/chip8_execute_unit_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// chip8 execute unit
// request channel (req_valid / req_stall) carries one command per transaction:
// execute an opcode, write a memory byte, read a memory byte or read a V register.
// response channel (rsp_valid / rsp_stall) returns one transaction per request
// with pc, I, read data and status.
// requests are taken one at a time; req_stall is high while a command is in work.
// a command runs from S_EXEC to S_DONE; ALU ops that write VF add S_WB, FX33
// adds S_BCD for its three digits, and FX55 and FX65 add S_LOOP over V0..VX, with
// registered register file and memory reads and one memory access per cycle.
// a new request is taken while the previous response still waits on rsp_stall;
// the finished result then holds in its last step until the output register frees.
// reset clears V0..VF, I and the stack pointer and loads pc with 512; the start_pc
// register resets to 512 and is read back over the APB port.
// memory and the call stack contents are undefined until written.
module chip8_execute_unit_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [15:0] opcode,
  input  wire logic [11:0] addr,
  input  wire logic [7:0]  wdata,
  input  wire logic [7:0]  rand_byte,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic      [15:0] pc_out,
  output logic      [15:0] index_out,
  output logic      [7:0]  rdata,
  output logic      [1:0]  status
);

  chip8eu_pkg::state_t state, state_next;

  logic [11:0] start_pc;
  logic [15:0] pc, pc_next;
  logic [15:0] idx, idx_next;
  logic [chip8eu_pkg::SP_W-1:0] sp, sp_next, sp_m1;
  logic [3:0] k, k_next;
  logic [1:0] res_status, res_status_next;
  logic [7:0] res_rdata, res_rdata_next;
  logic [7:0] alu_q, alu_q_next;
  logic [11:0] bcd_q, bcd_q_next;

  logic [1:0] cur_cmd;
  logic [15:0] cur_op;
  logic [11:0] cur_addr;
  logic [7:0] cur_wdata;
  logic [7:0] cur_rnd;

  logic accept, out_free;

  logic [3:0] va_addr, vb_addr;
  logic [7:0] va_q, vb_q;
  logic v_we;
  logic [3:0] v_waddr;
  logic [7:0] v_wdata;

  logic [chip8eu_pkg::MEM_AW-1:0] m_raddr, m_waddr;
  logic [7:0] m_q, m_wdata;
  logic m_we;

  logic [15:0] s_q;
  logic s_we;

  logic [3:0] top, x, y, n;
  logic [7:0] nn;
  logic [11:0] nnn;
  logic [8:0] sum9;
  logic [7:0] alu_res;
  logic alu_flag, alu_flag_op;
  logic [16:0] isum;

  assign accept = req_valid && !req_stall;
  assign req_stall = (state != chip8eu_pkg::S_IDLE);
  assign out_free = !rsp_valid || !rsp_stall;
  assign pready = 1'b1;
  assign prdata = (paddr == chip8eu_pkg::ADDR_START_PC) ? {20'd0, start_pc} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= chip8eu_pkg::PC_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr == chip8eu_pkg::ADDR_START_PC) begin
      start_pc <= pwdata[11:0];
    end
  end

  assign top = cur_op[15:12];
  assign x = cur_op[11:8];
  assign y = cur_op[7:4];
  assign n = cur_op[3:0];
  assign nn = cur_op[7:0];
  assign nnn = cur_op[11:0];
  assign sp_m1 = sp - chip8eu_pkg::SP_W'(1);

  // 8XY group
  always_comb begin
    sum9 = {1'b0, va_q} + {1'b0, vb_q};
    alu_res = 8'd0;
    alu_flag = 1'b0;
    alu_flag_op = n inside {chip8eu_pkg::ALU_ADD, chip8eu_pkg::ALU_SUB, chip8eu_pkg::ALU_SHR,
                            chip8eu_pkg::ALU_SUBN, chip8eu_pkg::ALU_SHL};
    case (n)
      chip8eu_pkg::ALU_MOV: alu_res = vb_q;
      chip8eu_pkg::ALU_OR: alu_res = va_q | vb_q;
      chip8eu_pkg::ALU_AND: alu_res = va_q & vb_q;
      chip8eu_pkg::ALU_XOR: alu_res = va_q ^ vb_q;
      chip8eu_pkg::ALU_ADD: begin
        alu_res = sum9[7:0];
        alu_flag = sum9[8];
      end
      chip8eu_pkg::ALU_SUB: begin
        alu_res = va_q - vb_q;
        alu_flag = (va_q >= vb_q);
      end
      chip8eu_pkg::ALU_SHR: begin
        alu_res = {1'b0, va_q[7:1]};
        alu_flag = va_q[0];
      end
      chip8eu_pkg::ALU_SUBN: begin
        alu_res = vb_q - va_q;
        alu_flag = (vb_q >= va_q);
      end
      chip8eu_pkg::ALU_SHL: begin
        alu_res = {va_q[6:0], 1'b0};
        alu_flag = va_q[7];
      end
      default: alu_res = 8'd0;
    endcase
  end

  assign isum = {1'b0, idx} + {9'd0, va_q};

  // read address steering
  always_comb begin
    vb_addr = (opcode[15:12] == chip8eu_pkg::OP_JPV0) ? 4'd0 : opcode[7:4];
    case (state)
      chip8eu_pkg::S_IDLE: begin
        va_addr = (cmd == chip8eu_pkg::CMD_VREG) ? addr[3:0] : opcode[11:8];
        m_raddr = chip8eu_pkg::mem_addr({5'd0, addr});
      end
      chip8eu_pkg::S_EXEC: begin
        va_addr = 4'd0;
        m_raddr = chip8eu_pkg::mem_addr({1'b0, idx});
      end
      default: begin
        va_addr = k + 4'd1;
        m_raddr = chip8eu_pkg::mem_addr({1'b0, idx} + {13'd0, k} + 17'd1);
      end
    endcase
  end

  always_comb begin
    state_next = state;
    pc_next = pc;
    idx_next = idx;
    sp_next = sp;
    k_next = k;
    res_status_next = res_status;
    res_rdata_next = res_rdata;
    alu_q_next = alu_q;
    bcd_q_next = bcd_q;
    v_we = 1'b0;
    v_waddr = x;
    v_wdata = 8'd0;
    m_we = 1'b0;
    m_waddr = chip8eu_pkg::mem_addr({1'b0, idx} + {13'd0, k});
    m_wdata = 8'd0;
    s_we = 1'b0;
    case (state)
      chip8eu_pkg::S_IDLE: begin
        if (accept) begin
          state_next = chip8eu_pkg::S_EXEC;
        end
      end
      chip8eu_pkg::S_EXEC: begin
        state_next = chip8eu_pkg::S_DONE;
        res_status_next = chip8eu_pkg::ST_OK;
        res_rdata_next = 8'd0;
        k_next = 4'd0;
        case (cur_cmd)
          chip8eu_pkg::CMD_WRITE: begin
            m_we = 1'b1;
            m_waddr = chip8eu_pkg::mem_addr({5'd0, cur_addr});
            m_wdata = cur_wdata;
          end
          chip8eu_pkg::CMD_READ: res_rdata_next = m_q;
          chip8eu_pkg::CMD_VREG: res_rdata_next = va_q;
          default: begin
            case (top)
              chip8eu_pkg::OP_SYS: begin
                if (cur_op != chip8eu_pkg::OPC_RET) begin
                  res_status_next = chip8eu_pkg::ST_UNIMPL;
                end else if (sp == '0) begin
                  res_status_next = chip8eu_pkg::ST_UNDERFLOW;
                end else begin
                  sp_next = sp_m1;
                  pc_next = s_q;
                end
              end
              chip8eu_pkg::OP_JP: pc_next = {4'd0, nnn};
              chip8eu_pkg::OP_CALL: begin
                if (sp >= chip8eu_pkg::SP_W'(chip8eu_pkg::STACK_DEPTH)) begin
                  res_status_next = chip8eu_pkg::ST_OVERFLOW;
                end else begin
                  s_we = 1'b1;
                  sp_next = sp + chip8eu_pkg::SP_W'(1);
                  pc_next = {4'd0, nnn};
                end
              end
              chip8eu_pkg::OP_SEI: begin
                if (va_q == nn) pc_next = pc + 16'd2;
              end
              chip8eu_pkg::OP_SNEI: begin
                if (va_q != nn) pc_next = pc + 16'd2;
              end
              chip8eu_pkg::OP_SER, chip8eu_pkg::OP_SNER: begin
                if (n != 4'd0) begin
                  res_status_next = chip8eu_pkg::ST_UNIMPL;
                end else if ((va_q == vb_q) == (top == chip8eu_pkg::OP_SER)) begin
                  pc_next = pc + 16'd2;
                end
              end
              chip8eu_pkg::OP_LDI: begin
                v_we = 1'b1;
                v_wdata = nn;
              end
              chip8eu_pkg::OP_ADDI: begin
                v_we = 1'b1;
                v_wdata = va_q + nn;
              end
              chip8eu_pkg::OP_ALU: begin
                if (!(n inside {[4'h0:4'h7], chip8eu_pkg::ALU_SHL})) begin
                  res_status_next = chip8eu_pkg::ST_UNIMPL;
                end else if (alu_flag_op) begin
                  v_we = 1'b1;
                  v_waddr = chip8eu_pkg::VF;
                  v_wdata = {7'd0, alu_flag};
                  alu_q_next = alu_res;
                  state_next = chip8eu_pkg::S_WB;
                end else begin
                  v_we = 1'b1;
                  v_wdata = alu_res;
                end
              end
              chip8eu_pkg::OP_LDIDX: idx_next = {4'd0, nnn};
              chip8eu_pkg::OP_JPV0: pc_next = {4'd0, nnn} + {8'd0, vb_q};
              chip8eu_pkg::OP_RND: begin
                v_we = 1'b1;
                v_wdata = cur_rnd & nn;
              end
              chip8eu_pkg::OP_MISC: begin
                case (nn)
                  chip8eu_pkg::FX_ADDIDX: begin
                    idx_next = isum[15:0];
                    v_we = 1'b1;
                    v_waddr = chip8eu_pkg::VF;
                    v_wdata = {7'd0, (isum > 17'hFFF)};
                  end
                  chip8eu_pkg::FX_BCD: begin
                    bcd_q_next = chip8eu_pkg::bcd_digits(va_q);
                    state_next = chip8eu_pkg::S_BCD;
                  end
                  chip8eu_pkg::FX_STORE, chip8eu_pkg::FX_LOAD: begin
                    state_next = chip8eu_pkg::S_LOOP;
                  end
                  default: res_status_next = chip8eu_pkg::ST_UNIMPL;
                endcase
              end
              default: res_status_next = chip8eu_pkg::ST_UNIMPL;
            endcase
          end
        endcase
      end
      chip8eu_pkg::S_WB: begin
        v_we = 1'b1;
        v_wdata = alu_q;
        state_next = chip8eu_pkg::S_DONE;
      end
      chip8eu_pkg::S_BCD: begin
        m_we = 1'b1;
        case (k)
          4'd0: m_wdata = {4'd0, bcd_q[11:8]};
          4'd1: m_wdata = {4'd0, bcd_q[7:4]};
          default: m_wdata = {4'd0, bcd_q[3:0]};
        endcase
        k_next = k + 4'd1;
        if (k == 4'd2) state_next = chip8eu_pkg::S_DONE;
      end
      chip8eu_pkg::S_LOOP: begin
        if (nn == chip8eu_pkg::FX_STORE) begin
          m_we = 1'b1;
          m_wdata = va_q;
        end else begin
          v_we = 1'b1;
          v_waddr = k;
          v_wdata = m_q;
        end
        k_next = k + 4'd1;
        if (k == x) state_next = chip8eu_pkg::S_DONE;
      end
      chip8eu_pkg::S_DONE: begin
        if (out_free) state_next = chip8eu_pkg::S_IDLE;
      end
      default: state_next = chip8eu_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chip8eu_pkg::S_IDLE;
      pc <= {4'd0, chip8eu_pkg::PC_RESET};
      idx <= 16'd0;
      sp <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pc <= pc_next;
      idx <= idx_next;
      sp <= sp_next;
      if (state == chip8eu_pkg::S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k <= k_next;
    res_status <= res_status_next;
    res_rdata <= res_rdata_next;
    alu_q <= alu_q_next;
    bcd_q <= bcd_q_next;
    if (accept) begin
      cur_cmd <= cmd;
      cur_op <= opcode;
      cur_addr <= addr;
      cur_wdata <= wdata;
      cur_rnd <= rand_byte;
    end
    if (state == chip8eu_pkg::S_DONE && out_free) begin
      pc_out <= pc;
      index_out <= idx;
      rdata <= res_rdata;
      status <= res_status;
    end
  end

  chip8eu_vregs u_vregs (
    .clk(clk),
    .rst(rst),
    .raddr_a(va_addr),
    .raddr_b(vb_addr),
    .rdata_a(va_q),
    .rdata_b(vb_q),
    .we(v_we),
    .waddr(v_waddr),
    .wdata(v_wdata)
  );

  chip8eu_ram #(
    .W(8),
    .AW(chip8eu_pkg::MEM_AW)
  ) u_mem (
    .clk(clk),
    .we(m_we),
    .waddr(m_waddr),
    .wdata(m_wdata),
    .raddr(m_raddr),
    .rdata(m_q)
  );

  chip8eu_ram #(
    .W(16),
    .AW(chip8eu_pkg::STACK_AW)
  ) u_stack (
    .clk(clk),
    .we(s_we),
    .waddr(sp[chip8eu_pkg::STACK_AW-1:0]),
    .wdata(pc),
    .raddr(sp_m1[chip8eu_pkg::STACK_AW-1:0]),
    .rdata(s_q)
  );

`ifndef NO_ASSERTIONS
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= chip8eu_pkg::SP_W'(chip8eu_pkg::STACK_DEPTH))
    else $error("stack pointer beyond depth");
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == chip8eu_pkg::S_EXEC)
    else $error("accepted transaction not executed");
  a_loop_op: assert property (@(posedge clk) disable iff (rst)
    state == chip8eu_pkg::S_LOOP |-> top == chip8eu_pkg::OP_MISC && k <= x)
    else $error("register block loop out of range");
  a_bcd_count: assert property (@(posedge clk) disable iff (rst)
    state == chip8eu_pkg::S_BCD |-> k <= 4'd2)
    else $error("bcd step count out of range");
`endif

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [15:0] pc;
    logic [15:0] idx;
    logic [7:0]  rdata;
    logic [1:0]  status;
  } rsp_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = chip8eu_pkg::ADDR_START_PC;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  cmd = chip8eu_pkg::CMD_EXEC;
  logic [15:0] opcode = '0;
  logic [11:0] addr = '0;
  logic [7:0]  wdata = '0;
  logic [7:0]  rand_byte = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [15:0] pc_out;
  logic [15:0] index_out;
  logic [7:0]  rdata;
  logic [1:0]  status;

  chip8_execute_unit_core i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_stall(req_stall),
    .cmd(cmd), .opcode(opcode), .addr(addr), .wdata(wdata), .rand_byte(rand_byte),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .pc_out(pc_out), .index_out(index_out), .rdata(rdata), .status(status)
  );

  always #5 clk = ~clk;

  // machine state mirror
  logic [7:0]  vreg_m [16];
  logic [15:0] idx_m;
  logic [15:0] pc_m;
  logic [15:0] stack_m [chip8eu_pkg::STACK_DEPTH];
  int          sp_m;
  logic [7:0]  mem_m [chip8eu_pkg::MEM_BYTES];
  bit          mem_set [chip8eu_pkg::MEM_BYTES];
  logic [11:0] set_addrs [$];
  logic [11:0] start_pc_m;

  rsp_t pending_rsp [$];
  int   errors = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  bit   hold_req = 1'b0;
  int   hold_cnt = 0;
  int   stall_left = 0;
  int   idle_cycles = 0;

  function automatic logic [11:0] mem_ix(input logic [16:0] a);
    return a[11:0];
  endfunction

  task automatic mem_store(input logic [16:0] a, input logic [7:0] d);
    logic [11:0] m;
    m = mem_ix(a);
    mem_m[m] = d;
    if (!mem_set[m]) begin
      mem_set[m] = 1'b1;
      set_addrs.push_back(m);
    end
  endtask

  task automatic chip8_step(input logic [1:0] c, input logic [15:0] op,
                            input logic [11:0] a, input logic [7:0] wd,
                            input logic [7:0] rb, output rsp_t r);
    logic [3:0]  x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn;
    logic [16:0] t;
    logic [1:0]  st;
    logic [7:0]  rd;
    x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
    vx = vreg_m[x]; vy = vreg_m[y];
    st = chip8eu_pkg::ST_OK; rd = '0;
    case (c)
      chip8eu_pkg::CMD_WRITE: mem_store({5'b0, a}, wd);
      chip8eu_pkg::CMD_READ: rd = mem_m[a];
      chip8eu_pkg::CMD_VREG: rd = vreg_m[a[3:0]];
      default: begin
        case (op[15:12])
          chip8eu_pkg::OP_SYS: begin
            if (op != chip8eu_pkg::OPC_RET) st = chip8eu_pkg::ST_UNIMPL;
            else if (sp_m == 0) st = chip8eu_pkg::ST_UNDERFLOW;
            else begin
              sp_m--;
              pc_m = stack_m[sp_m];
            end
          end
          chip8eu_pkg::OP_JP: pc_m = {4'b0, nnn};
          chip8eu_pkg::OP_CALL: begin
            if (sp_m >= chip8eu_pkg::STACK_DEPTH) st = chip8eu_pkg::ST_OVERFLOW;
            else begin
              stack_m[sp_m] = pc_m;
              sp_m++;
              pc_m = {4'b0, nnn};
            end
          end
          chip8eu_pkg::OP_SEI: if (vx == nn) pc_m = pc_m + 16'd2;
          chip8eu_pkg::OP_SNEI: if (vx != nn) pc_m = pc_m + 16'd2;
          chip8eu_pkg::OP_SER: begin
            if (n != 0) st = chip8eu_pkg::ST_UNIMPL;
            else if (vx == vy) pc_m = pc_m + 16'd2;
          end
          chip8eu_pkg::OP_SNER: begin
            if (n != 0) st = chip8eu_pkg::ST_UNIMPL;
            else if (vx != vy) pc_m = pc_m + 16'd2;
          end
          chip8eu_pkg::OP_LDI: vreg_m[x] = nn;
          chip8eu_pkg::OP_ADDI: vreg_m[x] = vx + nn;
          chip8eu_pkg::OP_ALU: begin
            case (n)
              chip8eu_pkg::ALU_MOV: vreg_m[x] = vy;
              chip8eu_pkg::ALU_OR: vreg_m[x] = vx | vy;
              chip8eu_pkg::ALU_AND: vreg_m[x] = vx & vy;
              chip8eu_pkg::ALU_XOR: vreg_m[x] = vx ^ vy;
              chip8eu_pkg::ALU_ADD: begin
                t = vx + vy;
                vreg_m[chip8eu_pkg::VF] = {7'b0, t > 17'hFF};
                vreg_m[x] = t[7:0];
              end
              chip8eu_pkg::ALU_SUB: begin
                vreg_m[chip8eu_pkg::VF] = {7'b0, vx >= vy};
                vreg_m[x] = vx - vy;
              end
              chip8eu_pkg::ALU_SHR: begin
                vreg_m[chip8eu_pkg::VF] = {7'b0, vx[0]};
                vreg_m[x] = vx >> 1;
              end
              chip8eu_pkg::ALU_SUBN: begin
                vreg_m[chip8eu_pkg::VF] = {7'b0, vy >= vx};
                vreg_m[x] = vy - vx;
              end
              chip8eu_pkg::ALU_SHL: begin
                vreg_m[chip8eu_pkg::VF] = {7'b0, vx[7]};
                vreg_m[x] = vx << 1;
              end
              default: st = chip8eu_pkg::ST_UNIMPL;
            endcase
          end
          chip8eu_pkg::OP_LDIDX: idx_m = {4'b0, nnn};
          chip8eu_pkg::OP_JPV0: pc_m = {4'b0, nnn} + {8'b0, vreg_m[0]};
          chip8eu_pkg::OP_RND: vreg_m[x] = rb & nn;
          chip8eu_pkg::OP_MISC: begin
            case (nn)
              chip8eu_pkg::FX_ADDIDX: begin
                t = idx_m + vx;
                idx_m = t[15:0];
                vreg_m[chip8eu_pkg::VF] = {7'b0, t > 17'hFFF};
              end
              chip8eu_pkg::FX_BCD: begin
                mem_store({1'b0, idx_m}, 8'(vx / 100));
                mem_store({1'b0, idx_m} + 17'd1, 8'((vx % 100) / 10));
                mem_store({1'b0, idx_m} + 17'd2, 8'(vx % 10));
              end
              chip8eu_pkg::FX_STORE:
                for (int k = 0; k <= x; k++)
                  mem_store({1'b0, idx_m} + 17'(k), vreg_m[k]);
              chip8eu_pkg::FX_LOAD:
                for (int k = 0; k <= x; k++)
                  vreg_m[k] = mem_m[mem_ix({1'b0, idx_m} + 17'(k))];
              default: st = chip8eu_pkg::ST_UNIMPL;
            endcase
          end
          default: st = chip8eu_pkg::ST_UNIMPL;
        endcase
      end
    endcase
    r.pc = pc_m; r.idx = idx_m; r.rdata = rd; r.status = st;
  endtask

  function automatic bit block_ready(input logic [3:0] x);
    for (int k = 0; k <= x; k++)
      if (!mem_set[mem_ix({1'b0, idx_m} + 17'(k))]) return 1'b0;
    return 1'b1;
  endfunction

  // one request transaction, predicted when accepted
  task automatic send_cmd(input logic [1:0] c, input logic [15:0] op,
                          input logic [11:0] a, input logic [7:0] wd,
                          input logic [7:0] rb);
    rsp_t r;
    int gap;
    cmd = c; opcode = op; addr = a; wdata = wd; rand_byte = rb;
    req_valid = 1'b1;
    do @(posedge clk); while (req_stall);
    chip8_step(c, op, a, wd, rb, r);
    pending_rsp.push_back(r);
    @(negedge clk);
    req_valid = 1'b0;
    gap = 0;
    if (!tx_quiet) begin
      if ($urandom_range(0, 99) < 5) gap = $urandom_range(10, 30);
      else if ($urandom_range(0, 99) < 25) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic exec(input logic [15:0] op);
    send_cmd(chip8eu_pkg::CMD_EXEC, op, 12'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    wait (pending_rsp.size() == 0);
    repeat (25) @(negedge clk);
  endtask

  task automatic apb_write(input logic [11:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = chip8eu_pkg::ADDR_START_PC;
    pwdata = {20'($urandom), v};
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    start_pc_m = v;
  endtask

  task automatic apb_check();
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b0; paddr = chip8eu_pkg::ADDR_START_PC;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[11:0] !== start_pc_m) begin
      $display("%0t start_pc readback expected %h actual %h", $time, start_pc_m, prdata);
      errors++;
    end
    @(negedge clk);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic test_config(input logic [11:0] v);
    drain();
    apb_check();
    apb_write(v);
    apb_check();
  endtask

  task automatic test_directed();
    exec(chip8eu_pkg::OPC_RET);
    exec(16'h00E0);
    exec(16'h60FF);
    exec(16'h6101);
    exec(16'h8014);
    exec(16'h8015);
    exec(16'h8017);
    exec(16'h6080);
    exec(16'h801E);
    exec(16'h8016);
    exec(16'h8F14);
    exec(16'h8018);
    exec(16'h5011);
    exec(16'h30FF);
    exec(16'h4000);
    exec(16'h5010);
    exec(16'h9010);
    exec(16'hC0FF);
    exec(16'hAFFE);
    exec(16'hFF55);
    exec(16'hFF65);
    exec(16'hF033);
    exec(16'hFF1E);
    exec(16'hBFFF);
    exec(16'hD123);
    exec(16'hE19E);
    exec(16'hF107);
    send_cmd(chip8eu_pkg::CMD_WRITE, 16'h0FFF, 12'hFFF, 8'hFF, 8'h00);
    send_cmd(chip8eu_pkg::CMD_READ, 16'hFFFF, 12'hFFF, 8'h00, 8'hFF);
    send_cmd(chip8eu_pkg::CMD_VREG, 16'h0000, 12'hFFF, 8'h00, 8'h00);
  endtask

  task automatic test_stack();
    repeat (chip8eu_pkg::STACK_DEPTH + 1) exec({chip8eu_pkg::OP_CALL, 12'($urandom)});
    repeat (chip8eu_pkg::STACK_DEPTH + 1) exec(chip8eu_pkg::OPC_RET);
  endtask

  task automatic random_item();
    logic [15:0] op;
    logic [1:0]  c;
    logic [11:0] a;
    int sel;
    op = 16'($urandom);
    a = 12'($urandom);
    sel = $urandom_range(0, 99);
    c = sel < 70 ? chip8eu_pkg::CMD_EXEC : sel < 85 ? chip8eu_pkg::CMD_WRITE :
        sel < 95 ? chip8eu_pkg::CMD_READ : chip8eu_pkg::CMD_VREG;
    if (c == chip8eu_pkg::CMD_READ) begin
      if (set_addrs.size() == 0) c = chip8eu_pkg::CMD_WRITE;
      else a = set_addrs[$urandom_range(0, set_addrs.size() - 1)];
    end
    case (op[15:12])
      chip8eu_pkg::OP_SYS: if ($urandom_range(0, 99) < 80) op = chip8eu_pkg::OPC_RET;
      chip8eu_pkg::OP_SER, chip8eu_pkg::OP_SNER:
        if ($urandom_range(0, 99) < 85) op[3:0] = 4'h0;
      chip8eu_pkg::OP_ALU: if ($urandom_range(0, 99) < 85) begin
        sel = $urandom_range(0, 8);
        op[3:0] = sel == 8 ? chip8eu_pkg::ALU_SHL : 4'(sel);
      end
      chip8eu_pkg::OP_MISC: if ($urandom_range(0, 99) < 90) begin
        sel = $urandom_range(0, 3);
        op[7:0] = sel == 0 ? chip8eu_pkg::FX_ADDIDX : sel == 1 ? chip8eu_pkg::FX_BCD :
                  sel == 2 ? chip8eu_pkg::FX_STORE : chip8eu_pkg::FX_LOAD;
      end
      default: ;
    endcase
    if (c == chip8eu_pkg::CMD_EXEC && op[15:12] == chip8eu_pkg::OP_MISC &&
        op[7:0] == chip8eu_pkg::FX_LOAD && !block_ready(op[11:8]))
      op[7:0] = chip8eu_pkg::FX_STORE;
    send_cmd(c, op, a, 8'($urandom), 8'($urandom));
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) tx_quiet = $urandom_range(0, 3) == 0;
      random_item();
    end
    tx_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    tx_quiet = 1'b1;
    for (int i = 0; i < 30; i++) random_item();
    tx_quiet = 1'b0;
  endtask

  // response side
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall = 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = 80;
      rsp_stall = 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_stall = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall = 1'b1;
    end else begin
      if ($urandom_range(0, 299) == 0) rx_quiet = ~rx_quiet;
      rsp_stall = 1'b0;
      if (!rx_quiet && $urandom_range(0, 99) < 20) begin
        stall_left = $urandom_range(0, 19) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3);
        rsp_stall = 1'b1;
        stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected response transaction pc %h", $time, pc_out);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (pc_out !== e.pc) begin
          $display("%0t pc_out expected %h actual %h", $time, e.pc, pc_out);
          errors++;
        end
        if (index_out !== e.idx) begin
          $display("%0t index_out expected %h actual %h", $time, e.idx, index_out);
          errors++;
        end
        if (rdata !== e.rdata) begin
          $display("%0t rdata expected %h actual %h", $time, e.rdata, rdata);
          errors++;
        end
        if (status !== e.status) begin
          $display("%0t status expected %h actual %h", $time, e.status, status);
          errors++;
        end
      end
    end
  end

  // watchdog on progress
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
      idle_cycles <= 0;
    end else if (pending_rsp.size() != 0 || req_valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) vreg_m[i] = '0;
    for (int i = 0; i < chip8eu_pkg::MEM_BYTES; i++) begin
      mem_m[i] = '0;
      mem_set[i] = 1'b0;
    end
    for (int i = 0; i < chip8eu_pkg::STACK_DEPTH; i++) stack_m[i] = '0;
    idx_m = '0; pc_m = 16'd512; sp_m = 0; start_pc_m = chip8eu_pkg::PC_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_config(12'hFFF);
    test_directed();
    test_stack();
    test_config(12'h000);
    test_random(800);
    test_backpressure();
    test_config(12'($urandom));
    test_random(750);
    test_config(chip8eu_pkg::PC_RESET);
    req_valid = 1'b0;
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== chip8_execute_unit_core.f =====
rtl/chip8eu_pkg.sv
rtl/chip8eu_ram.sv
rtl/chip8eu_vregs.sv
rtl/chip8_execute_unit_core.sv
tb/tb.sv
